FILE: rtl/tcw_pkg.sv
package tcw_pkg;

  // Screen geometry.
  localparam int COLUMNS    = 80;
  localparam int ROWS       = 25;
  localparam int TAB_WIDTH  = 8;
  localparam int CELL_COUNT = ROWS * COLUMNS;
  localparam int COPY_END   = CELL_COUNT - COLUMNS;

  // Field and storage widths.
  localparam int CHAR_W  = 8;
  localparam int ATTR_W  = 7;
  localparam int CELL_W  = ATTR_W + CHAR_W;
  localparam int IDX_W   = 11;
  localparam int CELL_AW = $clog2(CELL_COUNT);
  localparam int COL_W   = $clog2(COLUMNS + 1);
  localparam int ROW_W   = $clog2(ROWS + 1);
  localparam int TAB_W   = $clog2(TAB_WIDTH + 1);
  localparam int ACT_W   = 2;
  localparam int FG_W    = 4;
  localparam int BG_W    = 3;

  // Command queue; the depth must be a power of two.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Action codes on the command port.
  localparam logic [ACT_W-1:0] ACT_PRINT = 2'd0;
  localparam logic [ACT_W-1:0] ACT_CLEAR = 2'd1;
  localparam logic [ACT_W-1:0] ACT_READ  = 2'd2;

  // Register indexes on the configuration port.
  localparam logic CFG_TEXT_COLOR = 1'b0;
  localparam logic CFG_BACK_COLOR = 1'b1;

  // Character codes with a meaning of their own.
  localparam logic [CHAR_W-1:0] CH_TAB     = 8'd9;
  localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'd10;
  localparam logic [CHAR_W-1:0] CH_SPACE   = 8'h20;

  // Colours after reset.
  localparam logic [FG_W-1:0] RESET_TEXT_COLOR = 4'd14;
  localparam logic [BG_W-1:0] RESET_BACK_COLOR = 3'd1;
  localparam logic [ATTR_W-1:0] RESET_ATTR = {RESET_BACK_COLOR, RESET_TEXT_COLOR};

  // Classified commands passed from the front end to the back end.
  typedef enum logic [2:0] {
    OP_PUTC,
    OP_NEWLINE,
    OP_TAB,
    OP_CLEAR,
    OP_READ
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [CHAR_W-1:0] ch;
    logic [IDX_W-1:0]  idx;
  } cmd_t;

endpackage

FILE: rtl/text_console_writer_top.sv
// Channel   Signals                                   Transfer
// -------   ---------------------------------------   ------------------------------
// command   start, busy, action, char_code,           edge with start high, busy low
//           cell_index
// config    cfg_we, cfg_index, cfg_data               edge with cfg_we high
// result    done, cell_char, cell_attr,               edge that ends the done cycle
//           cursor_column, cursor_row
//
// In the back end a newline blanks the rest of its row cell by cell, a tab writes
// TAB_WIDTH spaces, a clear blanks every cell and a read fetches one cell. A scroll
// moves or blanks one cell per cycle: the rows move up, the copy is drained and the
// bottom row is blanked. A two-entry command queue lets the front end take new
// transfers while the back end works; busy rises when the queue is full.
// After reset the screen memory is swept to blanks and busy stays high meanwhile.
// The receiver cannot stall.
module text_console_writer_top
  import tcw_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic [ACT_W-1:0]  action,
  input  logic [CHAR_W-1:0] char_code,
  input  logic [IDX_W-1:0]  cell_index,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [FG_W-1:0]   cfg_data,
  output logic              done,
  output logic [CHAR_W-1:0] cell_char,
  output logic [ATTR_W-1:0] cell_attr,
  output logic [COL_W-1:0]  cursor_column,
  output logic [ROW_W-1:0]  cursor_row
);

  logic [FG_W-1:0] text_color;
  logic [BG_W-1:0] back_color;
  logic            push;
  cmd_t            push_cmd;
  logic            q_full;
  logic            q_valid;
  cmd_t            q_head;
  logic            q_pop;
  logic            init_busy;

  // The colour registers are sampled by the back end whenever a cell is
  // written or blanked, so a change applies to all later output.
  always_ff @(posedge clk) begin
    if (rst) begin
      text_color <= RESET_TEXT_COLOR;
      back_color <= RESET_BACK_COLOR;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_TEXT_COLOR: text_color <= cfg_data;
        CFG_BACK_COLOR: back_color <= cfg_data[BG_W-1:0];
        default:        text_color <= text_color;
      endcase
    end
  end

  // The block refuses transfers while the queue is full or the screen is
  // still being blanked after reset.
  assign busy = q_full || init_busy;

  tcw_front u_front (
    .start      (start),
    .busy       (busy),
    .action     (action),
    .char_code  (char_code),
    .cell_index (cell_index),
    .push       (push),
    .cmd        (push_cmd)
  );

  tcw_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .valid    (q_valid),
    .head     (q_head),
    .pop      (q_pop)
  );

  tcw_back u_back (
    .clk           (clk),
    .rst           (rst),
    .attr          ({back_color, text_color}),
    .q_valid       (q_valid),
    .q_cmd         (q_head),
    .q_pop         (q_pop),
    .init_busy     (init_busy),
    .done          (done),
    .cell_char     (cell_char),
    .cell_attr     (cell_attr),
    .cursor_column (cursor_column),
    .cursor_row    (cursor_row)
  );

endmodule

FILE: rtl/tcw_front.sv
module tcw_front
  import tcw_pkg::*;
(
  input  logic              start,
  input  logic              busy,
  input  logic [ACT_W-1:0]  action,
  input  logic [CHAR_W-1:0] char_code,
  input  logic [IDX_W-1:0]  cell_index,
  output logic              push,
  output cmd_t              cmd
);

  logic accept;

  assign accept = start && !busy;

  // Sort the accepted item into a command; the unused action is dropped here.
  always_comb begin
    cmd.ch  = char_code;
    cmd.idx = cell_index;
    cmd.op  = OP_PUTC;
    push    = 1'b0;
    unique case (action)
      ACT_PRINT: begin
        push = accept;
        if (char_code == CH_NEWLINE) begin
          cmd.op = OP_NEWLINE;
        end else if (char_code == CH_TAB) begin
          cmd.op = OP_TAB;
        end else begin
          cmd.op = OP_PUTC;
        end
      end
      ACT_CLEAR: begin
        push   = accept;
        cmd.op = OP_CLEAR;
      end
      ACT_READ: begin
        push   = accept;
        cmd.op = OP_READ;
      end
      default: begin
        push = 1'b0;
      end
    endcase
  end

endmodule

FILE: rtl/tcw_queue.sv
module tcw_queue
  import tcw_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  output logic valid,
  output cmd_t head,
  input  logic pop
);

  cmd_t              entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_push;
  logic              do_pop;

  assign full    = (count == QCNT_W'(QUEUE_DEPTH));
  assign valid   = (count != '0);
  assign head    = entries[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = pop && valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

endmodule

FILE: rtl/tcw_back.sv
module tcw_back
  import tcw_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic [ATTR_W-1:0] attr,
  input  logic              q_valid,
  input  cmd_t              q_cmd,
  output logic              q_pop,
  output logic              init_busy,
  output logic              done,
  output logic [CHAR_W-1:0] cell_char,
  output logic [ATTR_W-1:0] cell_attr,
  output logic [COL_W-1:0]  cursor_column,
  output logic [ROW_W-1:0]  cursor_row
);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PLAIN,
    ST_NL,
    ST_SCR_COPY,
    ST_SCR_BLANK,
    ST_READ
  } state_t;

  state_t             state;
  op_t                op;
  logic [CHAR_W-1:0]  ch;
  logic [TAB_W-1:0]   tab_left;
  logic [COL_W-1:0]   col;
  logic [ROW_W-1:0]   row;
  logic [CELL_AW-1:0] idx;
  logic               ret_plain;
  logic               cp_v;
  logic [CELL_AW-1:0] cp_dst;
  logic               rd_oor;

  logic [CELL_W-1:0]  mem [CELL_COUNT];
  logic [CELL_W-1:0]  rd_data;
  logic               mem_we;
  logic [CELL_AW-1:0] mem_wa;
  logic [CELL_W-1:0]  mem_wd;
  logic               mem_re;
  logic [CELL_AW-1:0] mem_ra;

  logic [CELL_AW-1:0] cur_addr;
  logic [CELL_W-1:0]  blank;
  logic               col_past;
  logic               row_past;
  logic               q_in_range;

  assign cur_addr   = CELL_AW'(row) * CELL_AW'(COLUMNS) + CELL_AW'(col);
  assign blank      = {(init_busy ? RESET_ATTR : attr), CH_SPACE};
  assign col_past   = (col >= COL_W'(COLUMNS));
  assign row_past   = (row >= ROW_W'(ROWS));
  assign q_in_range = ({1'b0, q_cmd.idx} < (IDX_W + 1)'(CELL_COUNT));
  assign q_pop      = (state == ST_IDLE) && q_valid;

  // Memory port control.
  always_comb begin
    mem_we = 1'b0;
    mem_wa = cur_addr;
    mem_wd = blank;
    mem_re = 1'b0;
    mem_ra = CELL_AW'(q_cmd.idx);
    unique case (state)
      ST_CLEAR: begin
        mem_we = 1'b1;
        mem_wa = idx;
      end
      ST_IDLE: begin
        mem_re = q_valid && (q_cmd.op == OP_READ) && q_in_range;
      end
      ST_PLAIN: begin
        mem_we = !col_past && !row_past;
        mem_wd = {attr, ((op == OP_TAB) ? CH_SPACE : ch)};
      end
      ST_NL: begin
        mem_we = !col_past && !row_past;
      end
      ST_SCR_COPY: begin
        // Read a row below, write the cell fetched in the previous cycle.
        mem_re = (idx < CELL_AW'(COPY_END));
        mem_ra = idx + CELL_AW'(COLUMNS);
        mem_we = cp_v;
        mem_wa = cp_dst;
        mem_wd = rd_data;
      end
      ST_SCR_BLANK: begin
        mem_we = 1'b1;
        mem_wa = idx;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rd_data <= mem[mem_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      init_busy <= 1'b1;
      idx       <= '0;
      col       <= '0;
      row       <= '0;
      cp_v      <= 1'b0;
      done      <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        ST_CLEAR: begin
          idx <= idx + 1'b1;
          if (idx == CELL_AW'(CELL_COUNT - 1)) begin
            col       <= '0;
            row       <= '0;
            init_busy <= 1'b0;
            state     <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (q_valid) begin
            op       <= q_cmd.op;
            ch       <= q_cmd.ch;
            tab_left <= TAB_W'(TAB_WIDTH);
            unique case (q_cmd.op) inside
              OP_PUTC, OP_TAB: state <= ST_PLAIN;
              OP_NEWLINE:      state <= ST_NL;
              OP_CLEAR: begin
                idx   <= '0;
                state <= ST_CLEAR;
              end
              OP_READ: begin
                rd_oor <= !q_in_range;
                state  <= ST_READ;
              end
              default:         state <= ST_IDLE;
            endcase
          end
        end
        ST_PLAIN: begin
          if (col_past) begin
            state <= ST_NL;
          end else if (row_past) begin
            idx       <= '0;
            cp_v      <= 1'b0;
            ret_plain <= 1'b1;
            state     <= ST_SCR_COPY;
          end else begin
            col <= col + 1'b1;
            if ((op == OP_TAB) && (tab_left > TAB_W'(1))) begin
              tab_left <= tab_left - 1'b1;
            end else begin
              state <= ST_IDLE;
            end
          end
        end
        ST_NL: begin
          if (row_past) begin
            idx       <= '0;
            cp_v      <= 1'b0;
            ret_plain <= 1'b0;
            state     <= ST_SCR_COPY;
          end else if (!col_past) begin
            col <= col + 1'b1;
          end else begin
            col   <= '0;
            row   <= row + 1'b1;
            state <= (op == OP_NEWLINE) ? ST_IDLE : ST_PLAIN;
          end
        end
        ST_SCR_COPY: begin
          cp_v   <= mem_re;
          cp_dst <= idx;
          if (mem_re) begin
            idx <= idx + 1'b1;
          end else begin
            // The index already points at the first cell of the last row.
            state <= ST_SCR_BLANK;
          end
        end
        ST_SCR_BLANK: begin
          idx <= idx + 1'b1;
          if (idx == CELL_AW'(CELL_COUNT - 1)) begin
            row   <= ROW_W'(ROWS - 1);
            col   <= '0;
            state <= ret_plain ? ST_PLAIN : ST_NL;
          end
        end
        ST_READ: begin
          done          <= 1'b1;
          cell_char     <= rd_oor ? '0 : rd_data[CHAR_W-1:0];
          cell_attr     <= rd_oor ? '0 : rd_data[CELL_W-1:CHAR_W];
          cursor_column <= col;
          cursor_row    <= row;
          state         <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: test/text_console_writer_top_tb.sv
module text_console_writer_top_tb
  import tcw_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  // The action code that the block must ignore.
  localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;

  // Idle time after the last transfer of a phase. A clear or a scroll can still
  // be walking the screen memory, so this covers both with room to spare.
  localparam int SETTLE_CYCLES = 2 * CELL_COUNT + 100;

  // Longest wait for outstanding reads once every command has been taken.
  localparam int DRAIN_LIMIT = 4 * CELL_COUNT + 500;

  localparam int RANDOM_PER_PHASE = 185;
  localparam int PHASES           = 6;

  typedef struct packed {
    logic [ACT_W-1:0]  act;
    logic [CHAR_W-1:0] ch;
    logic [IDX_W-1:0]  idx;
  } console_req_t;

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic [ATTR_W-1:0] attr;
    logic [COL_W-1:0]  col;
    logic [ROW_W-1:0]  row;
  } cell_report_t;

  logic              clk;
  logic              rst        = 1'b1;
  logic              start      = 1'b0;
  logic              busy;
  logic [ACT_W-1:0]  action     = '0;
  logic [CHAR_W-1:0] char_code  = '0;
  logic [IDX_W-1:0]  cell_index = '0;
  logic              cfg_we     = 1'b0;
  logic              cfg_index  = 1'b0;
  logic [FG_W-1:0]   cfg_data   = '0;
  logic              done;
  logic [CHAR_W-1:0] cell_char;
  logic [ATTR_W-1:0] cell_attr;
  logic [COL_W-1:0]  cursor_column;
  logic [ROW_W-1:0]  cursor_row;

  text_console_writer_top uut (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .action        (action),
    .char_code     (char_code),
    .cell_index    (cell_index),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .done          (done),
    .cell_char     (cell_char),
    .cell_attr     (cell_attr),
    .cursor_column (cursor_column),
    .cursor_row    (cursor_row)
  );

  // Shadow copy of the console: the screen, the cursor and the colours.
  logic [CELL_W-1:0] shadow_screen [CELL_COUNT];
  int                cur_col;
  int                cur_row;
  logic [FG_W-1:0]   fg_colour;
  logic [BG_W-1:0]   bg_colour;

  // Cell reads still owed by the block, oldest first.
  cell_report_t      owed_reports [$];

  // Commands waiting to be offered on the command port.
  console_req_t      pending_cmds [$];
  console_req_t      next_req;

  int gap_left;
  int no_idle_left;
  int error_count;
  int n_queued, n_accepted, phase_items;
  int n_prints, n_newlines, n_tabs, n_clears, n_reads, n_unused;
  int n_scrolls, n_wraps, n_colour_writes, n_checked;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // A generous ceiling: even a run in which every transfer forced a full sweep
  // of the screen memory would end well inside it.
  initial begin
    #1s;
    $display("Simulation FAILED");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Shadow model of the console.
  // ---------------------------------------------------------------------------

  function automatic logic [ATTR_W-1:0] current_attr();
    return {bg_colour, fg_colour};
  endfunction

  function automatic logic [CELL_W-1:0] blank_word();
    return {current_attr(), CH_SPACE};
  endfunction

  function automatic void wipe_screen();
    for (int i = 0; i < CELL_COUNT; i++) shadow_screen[i] = blank_word();
    cur_col = 0;
    cur_row = 0;
  endfunction

  // Everything moves up a row; the freed bottom row is blanked in the current
  // colours and the cursor lands at its start.
  function automatic void scroll_screen();
    for (int i = 0; i < COPY_END; i++) shadow_screen[i] = shadow_screen[i + COLUMNS];
    for (int i = COPY_END; i < CELL_COUNT; i++) shadow_screen[i] = blank_word();
    cur_row = ROWS - 1;
    cur_col = 0;
    n_scrolls++;
  endfunction

  // Newline: blank what is left of the row and drop to column 0 of the next
  // one. With a scroll pending the scroll happens first, so the blanked row is
  // the new bottom row and a scroll is pending again afterwards.
  function automatic void feed_line();
    if (cur_row >= ROWS) scroll_screen();
    for (int c = cur_col; c < COLUMNS; c++) shadow_screen[cur_row * COLUMNS + c] = blank_word();
    cur_col = 0;
    cur_row++;
  endfunction

  function automatic void put_glyph(logic [CHAR_W-1:0] ch);
    if (cur_col >= COLUMNS) begin
      feed_line();
      n_wraps++;
    end
    if (cur_row >= ROWS) scroll_screen();
    shadow_screen[cur_row * COLUMNS + cur_col] = {current_attr(), ch};
    cur_col++;
  endfunction

  // Applies one accepted command and, for a read, records the report owed.
  function automatic void apply_command(logic [ACT_W-1:0] act, logic [CHAR_W-1:0] ch,
                                        logic [IDX_W-1:0] idx);
    cell_report_t      rep;
    logic [CELL_W-1:0] word;
    n_accepted++;
    case (act)
      ACT_PRINT: begin
        if (ch == CH_NEWLINE) begin
          feed_line();
          n_newlines++;
        end else if (ch == CH_TAB) begin
          for (int i = 0; i < TAB_WIDTH; i++) put_glyph(CH_SPACE);
          n_tabs++;
        end else begin
          put_glyph(ch);
          n_prints++;
        end
      end
      ACT_CLEAR: begin
        wipe_screen();
        n_clears++;
      end
      ACT_READ: begin
        word     = (idx < CELL_COUNT) ? shadow_screen[idx] : '0;
        rep.ch   = word[CHAR_W-1:0];
        rep.attr = word[CELL_W-1:CHAR_W];
        rep.col  = COL_W'(cur_col);
        rep.row  = ROW_W'(cur_row);
        owed_reports.push_back(rep);
        n_reads++;
      end
      default: n_unused++;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: offers queued commands, with a random pause before each one.
  // ---------------------------------------------------------------------------

  // Random pauses, broken now and then by stretches with none.
  function automatic int draw_gap();
    if (no_idle_left > 0) begin
      no_idle_left--;
      return 0;
    end
    if ($urandom_range(0, 19) == 0) begin
      no_idle_left = $urandom_range(20, 80);
      return 0;
    end
    return $urandom_range(0, 13);
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      // A transfer happens on this edge: fold it into the shadow model first.
      if (start && !busy) begin
        apply_command(action, char_code, cell_index);
      end
      // Start stays high until taken; after that a fresh command may follow.
      if (!start || !busy) begin
        if (gap_left > 0) begin
          gap_left--;
          start <= 1'b0;
        end else if (pending_cmds.size() > 0) begin
          next_req   = pending_cmds.pop_front();
          action     <= next_req.act;
          char_code  <= next_req.ch;
          cell_index <= next_req.idx;
          start      <= 1'b1;
          gap_left   = draw_gap();
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: every strobed result is checked against the oldest owed report.
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    cell_report_t exp_rep;
    if (!rst && done) begin
      if (owed_reports.size() == 0) begin
        $error("result with no read outstanding: char %0d attr %0d col %0d row %0d",
               cell_char, cell_attr, cursor_column, cursor_row);
        error_count++;
      end else begin
        exp_rep = owed_reports.pop_front();
        n_checked++;
        if (cell_char !== exp_rep.ch) begin
          $error("cell_char: expected %0d, actual %0d", exp_rep.ch, cell_char);
          error_count++;
        end
        if (cell_attr !== exp_rep.attr) begin
          $error("cell_attr: expected %0d, actual %0d", exp_rep.attr, cell_attr);
          error_count++;
        end
        if (cursor_column !== exp_rep.col) begin
          $error("cursor_column: expected %0d, actual %0d", exp_rep.col, cursor_column);
          error_count++;
        end
        if (cursor_row !== exp_rep.row) begin
          $error("cursor_row: expected %0d, actual %0d", exp_rep.row, cursor_row);
          error_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus.
  // ---------------------------------------------------------------------------

  task automatic queue_req(logic [ACT_W-1:0] act, logic [CHAR_W-1:0] ch,
                           logic [IDX_W-1:0] idx);
    console_req_t req;
    req.act = act;
    req.ch  = ch;
    req.idx = idx;
    pending_cmds.push_back(req);
    n_queued++;
    if (act != ACT_UNUSED) phase_items++;
  endtask

  // Fields that the action does not use are filled at random.
  task automatic queue_print(logic [CHAR_W-1:0] ch);
    queue_req(ACT_PRINT, ch, IDX_W'($urandom()));
  endtask

  task automatic queue_read(logic [IDX_W-1:0] idx);
    queue_req(ACT_READ, CHAR_W'($urandom()), idx);
  endtask

  // Reads favour the bottom rows, where scrolling keeps the contents moving,
  // and now and then point past the end of the screen.
  function automatic logic [IDX_W-1:0] pick_cell();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return IDX_W'($urandom_range(CELL_COUNT, (1 << IDX_W) - 1));
    if (r < 40) return IDX_W'($urandom_range(COPY_END - COLUMNS, CELL_COUNT - 1));
    return IDX_W'($urandom_range(0, CELL_COUNT - 1));
  endfunction

  // A line of text: mostly short, some long enough to wrap, with tabs and
  // reads mixed in, usually closed by a newline.
  task automatic queue_text_line();
    int len;
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) len = $urandom_range(0, 20);
    else if (r < 85) len = $urandom_range(21, 79);
    else len = $urandom_range(80, 170);
    for (int k = 0; k < len; k++) begin
      if ($urandom_range(0, 99) < 8) queue_print(CH_TAB);
      else queue_print(CHAR_W'($urandom_range(0, 255)));
      if ($urandom_range(0, 99) < 12) queue_read(pick_cell());
    end
    if ($urandom_range(0, 99) < 85) queue_print(CH_NEWLINE);
  endtask

  task automatic queue_random_phase(int target);
    int r;
    int n;
    phase_items = 0;
    while (phase_items < target) begin
      r = $urandom_range(0, 99);
      if (r < 70) begin
        queue_text_line();
      end else if (r < 80) begin
        n = $urandom_range(1, 6);
        repeat (n) queue_read(pick_cell());
      end else if (r < 86) begin
        // Noise: any action, any field values.
        queue_req(ACT_W'($urandom()), CHAR_W'($urandom()), IDX_W'($urandom()));
      end else if (r < 91) begin
        n = $urandom_range(1, 4);
        repeat (n) queue_print(CH_NEWLINE);
      end else if (r < 94) begin
        queue_req(ACT_CLEAR, CHAR_W'($urandom()), IDX_W'($urandom()));
      end else begin
        n = $urandom_range(1, 12);
        repeat (n) queue_print(CH_TAB);
      end
    end
    // A closing read: its report can only come once all earlier work is done.
    queue_read(pick_cell());
  endtask

  // Waits until every queued command has been taken and every read answered,
  // then lets a possible clear or scroll behind the last report finish.
  task automatic wait_until_idle();
    int waited;
    while (n_accepted != n_queued) @(posedge clk);
    waited = 0;
    while (owed_reports.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (owed_reports.size() != 0) begin
      $error("%0d read results never arrived", owed_reports.size());
      error_count++;
      owed_reports.delete();
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_colour_reg(logic idx, logic [FG_W-1:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_TEXT_COLOR) fg_colour = value;
    else bg_colour = value[BG_W-1:0];
    n_colour_writes++;
  endtask

  initial begin
    fg_colour = RESET_TEXT_COLOR;
    bg_colour = RESET_BACK_COLOR;
    wipe_screen();

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed opening in the reset colours. The driver holds the first
    // command until the start-up sweep of the screen memory lets go of busy.
    queue_read(IDX_W'(0));
    queue_read(IDX_W'(CELL_COUNT - 1));
    queue_read(IDX_W'(CELL_COUNT));                  // just past the screen
    queue_read({IDX_W{1'b1}});                       // far past the screen
    queue_req(ACT_UNUSED, 8'hFF, {IDX_W{1'b1}});     // must change nothing
    queue_print(8'h00);
    queue_print(8'hFF);
    queue_print(8'h41);
    queue_print(CH_TAB);
    queue_read(IDX_W'(3));
    queue_read(IDX_W'(10));
    queue_print(CH_NEWLINE);
    queue_read(IDX_W'(20));
    queue_read(IDX_W'(COLUMNS));
    queue_req(ACT_CLEAR, 8'hFF, {IDX_W{1'b1}});
    queue_read(IDX_W'(1));
    queue_print(8'h7F);
    queue_print(CH_NEWLINE);
    queue_print(CH_NEWLINE);
    queue_read(IDX_W'(0));
    queue_read(IDX_W'(COLUMNS));

    // Each phase runs in its own colours; the first keeps the reset ones,
    // then both extremes, then random settings. Writing the back colour with
    // the top data bit set checks that the bit is dropped.
    for (int p = 0; p < PHASES; p++) begin
      if (p == 1) begin
        write_colour_reg(CFG_TEXT_COLOR, 4'd0);
        write_colour_reg(CFG_BACK_COLOR, 4'd0);
      end else if (p == 2) begin
        write_colour_reg(CFG_TEXT_COLOR, 4'd15);
        write_colour_reg(CFG_BACK_COLOR, 4'd15);
      end else if (p > 2) begin
        write_colour_reg(CFG_TEXT_COLOR, FG_W'($urandom()));
        write_colour_reg(CFG_BACK_COLOR, FG_W'($urandom()));
      end
      queue_random_phase(RANDOM_PER_PHASE);
      wait_until_idle();
    end

    $display("Transfers: %0d (%0d characters, %0d newlines, %0d tabs, %0d clears,",
             n_accepted, n_prints, n_newlines, n_tabs, n_clears);
    $display("  %0d reads, %0d unused).", n_reads, n_unused);
    $display("Checked %0d results across %0d scrolls, %0d wraps and %0d colour writes.",
             n_checked, n_scrolls, n_wraps, n_colour_writes);
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
